@@ rtl/core/dpls_pkg.sv @@
// shared types, constants and helper functions for the drive power limit scaler
package dpls_pkg;

    // request and result payloads
    typedef struct packed {
        logic signed [15:0] drive_lf;
        logic signed [15:0] drive_rf;
        logic signed [15:0] drive_lb;
        logic signed [15:0] drive_rb;
        logic signed [15:0] target_forward;
        logic signed [15:0] target_sideways;
        logic signed [15:0] target_rotation;
        logic signed [15:0] measured_forward;
        logic signed [15:0] measured_sideways;
        logic signed [15:0] measured_rotation;
        logic        [9:0]  power_buffer;
        logic               referee_online;
    } cmd_item_t;

    typedef struct packed {
        logic signed [15:0] limited_lf;
        logic signed [15:0] limited_rf;
        logic signed [15:0] limited_lb;
        logic signed [15:0] limited_rb;
        logic               was_limited;
        logic        [15:0] output_budget;
    } res_item_t;

    // configuration and arithmetic constants
    localparam logic [15:0] OUTPUT_MAX_RESET = 16'd50000;
    localparam logic [5:0]  BUF_FULL         = 6'd60;
    localparam logic [5:0]  BUF_LOW          = 6'd18;
    // 60^2, the square curve coefficient at a full buffer
    localparam logic [12:0] COEF_FULL        = 13'd3600;
    // ceil(2^22 / 10), exact for magnitudes below 699050
    localparam logic [18:0] RECIP10          = 19'd419431;
    localparam int          RECIP10_SHIFT    = 22;

    // budget denominators 60^3 and 60^2 as rounded-up reciprocals,
    // exact for products below 2^29
    localparam longint      DEN_CUBE           = 216000;
    localparam longint      DEN_SQUARE         = 3600;
    localparam int          RECIP_CUBE_SHIFT   = 47;
    localparam int          RECIP_SQUARE_SHIFT = 41;
    localparam logic [29:0] RECIP_CUBE         =
        30'(((longint'(1) << RECIP_CUBE_SHIFT) + DEN_CUBE - 1) / DEN_CUBE);
    localparam logic [29:0] RECIP_SQUARE       =
        30'(((longint'(1) << RECIP_SQUARE_SHIFT) + DEN_SQUARE - 1) / DEN_SQUARE);

    localparam int NUM_LANES = 4;
    localparam int LANE_LF   = 0;
    localparam int LANE_RF   = 1;
    localparam int LANE_LB   = 2;
    localparam int LANE_RB   = 3;

    // divider shape: 34-bit dividend, 18-bit divisor, one quotient bit per stage
    localparam int DIV_STEPS = 16;
    localparam int DIV_NUM_W = 34;
    localparam int DIV_DEN_W = 18;

    // pipeline stage numbers
    localparam int ST_IN        = 0;
    localparam int ST_PREP      = 1;
    localparam int ST_RECIP     = 2;
    localparam int ST_NUDGE     = 3;
    localparam int ST_SUM       = 4;
    localparam int ST_BUDGET    = ST_SUM;
    localparam int ST_CMP       = ST_BUDGET + 1;
    localparam int ST_SCALE_MUL = ST_CMP + 1;
    localparam int ST_SDIV_LAST = ST_SCALE_MUL + DIV_STEPS;
    localparam int ST_OUT       = ST_SDIV_LAST + 1;
    localparam int NUM_STAGES   = ST_OUT + 1;

    typedef logic [NUM_STAGES-1:0] stage_en_t;

    // budget compare result handed from the merge stage to the lanes
    typedef struct packed {
        logic        limited;
        logic [15:0] budget;
        logic [17:0] sum;
    } merge_t;

    // what the merge stage carries to the output register
    typedef struct packed {
        logic        limited;
        logic [15:0] budget;
    } tail_t;

    // budget numerator coefficient for a clamped buffer reading: b^3 or b^2
    function automatic logic [12:0] budget_coef(input logic [5:0] b);
        int bi;
        bi = int'(b);
        if (b < BUF_LOW)
            budget_coef = 13'(bi * bi * bi);
        else
            budget_coef = 13'(bi * bi);
    endfunction

    // sign of target minus measured, as -1, 0 or +1
    function automatic logic signed [1:0] speed_sign(input logic signed [15:0] tgt,
                                                      input logic signed [15:0] meas);
        logic signed [16:0] diff;
        diff = $signed({tgt[15], tgt}) - $signed({meas[15], meas});
        if (diff > 17'sd0)
            speed_sign = 2'sb01;
        else if (diff < 17'sd0)
            speed_sign = 2'sb11;
        else
            speed_sign = 2'sb00;
    endfunction

    // apply a sign to a magnitude and saturate to 16-bit signed
    function automatic logic [15:0] sat_mag(input logic neg, input logic [15:0] mag);
        if (neg)
            sat_mag = mag[15] ? 16'h8000 : 16'(~mag + 16'd1);
        else
            sat_mag = mag[15] ? 16'h7FFF : mag;
    endfunction

endpackage

@@ rtl/core/drive_power_limit_scaler.sv @@
// top level: request register, stage control, budget unit, four lanes, merge, result register
// throughput: one request per cycle unless res_stall backs up a full pipeline; the 16-stage
//   restoring dividers of the lane scaling are fully pipelined, and bubbles close up while a result waits to be taken
// reset: rst_n clears all stage valid flags and loads output_max with 50000; data
//   registers are not reset
module drive_power_limit_scaler (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  dpls_pkg::cmd_item_t cmd_data,
    output logic                res_valid,
    input  logic                res_stall,
    output dpls_pkg::res_item_t res_data,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata
);

    logic [15:0]         output_max_reg;
    dpls_pkg::stage_en_t v_reg;
    dpls_pkg::stage_en_t v_next;
    dpls_pkg::stage_en_t ready;
    dpls_pkg::cmd_item_t cmd_reg;
    dpls_pkg::res_item_t res_reg;
    dpls_pkg::res_item_t res_next;

    logic signed [1:0] sign_fwd;
    logic signed [1:0] sign_side;
    logic signed [1:0] sign_rot;
    logic signed [2:0] ef;
    logic signed [2:0] er;
    logic signed [2:0] ec;

    logic signed [dpls_pkg::NUM_LANES-1:0][15:0] lane_cmd;
    logic signed [dpls_pkg::NUM_LANES-1:0][2:0]  lane_err;
    logic [dpls_pkg::NUM_LANES-1:0][15:0]        lane_mag;
    logic [dpls_pkg::NUM_LANES-1:0][15:0]        lane_res;
    logic [15:0]                                 budget;
    dpls_pkg::merge_t                            cmp;
    dpls_pkg::tail_t                             tail;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            output_max_reg <= dpls_pkg::OUTPUT_MAX_RESET;
        else if (cfg_we)
            output_max_reg <= cfg_wdata;
    end

    // a stage loads when it is empty or the stage after it loads
    always_comb
    begin
        ready[dpls_pkg::NUM_STAGES-1] = !v_reg[dpls_pkg::NUM_STAGES-1] || !res_stall;
        for (int i = dpls_pkg::NUM_STAGES - 2; i >= 0; i--)
            ready[i] = !v_reg[i] || ready[i+1];
    end

    // valid flags move with the data
    always_comb
    begin
        v_next[0] = ready[0] ? cmd_valid : v_reg[0];
        for (int i = 1; i < dpls_pkg::NUM_STAGES; i++)
            v_next[i] = ready[i] ? v_reg[i-1] : v_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign cmd_stall = !ready[dpls_pkg::ST_IN];

    // request register
    always_ff @(posedge clk)
    begin
        if (ready[dpls_pkg::ST_IN])
            cmd_reg <= cmd_data;
    end

    // speed error signs and mecanum error sums
    always_comb
    begin
        sign_fwd  = dpls_pkg::speed_sign(cmd_reg.target_forward, cmd_reg.measured_forward);
        sign_side = dpls_pkg::speed_sign(cmd_reg.target_sideways, cmd_reg.measured_sideways);
        sign_rot  = dpls_pkg::speed_sign(cmd_reg.target_rotation, cmd_reg.measured_rotation);
        ef = {sign_fwd[1], sign_fwd};
        er = {sign_side[1], sign_side};
        ec = {sign_rot[1], sign_rot};
        lane_err[dpls_pkg::LANE_LF] =  ef + er + ec;
        lane_err[dpls_pkg::LANE_RF] = -ef + er + ec;
        lane_err[dpls_pkg::LANE_LB] =  ef - er + ec;
        lane_err[dpls_pkg::LANE_RB] = -ef - er + ec;
        lane_cmd[dpls_pkg::LANE_LF] = cmd_reg.drive_lf;
        lane_cmd[dpls_pkg::LANE_RF] = cmd_reg.drive_rf;
        lane_cmd[dpls_pkg::LANE_LB] = cmd_reg.drive_lb;
        lane_cmd[dpls_pkg::LANE_RB] = cmd_reg.drive_rb;
    end

    dpls_budget u_budget (
        .clk            (clk),
        .en             (ready),
        .power_buffer   (cmd_reg.power_buffer),
        .referee_online (cmd_reg.referee_online),
        .output_max     (output_max_reg),
        .budget         (budget)
    );

    // wheel lanes
    for (genvar g = 0; g < dpls_pkg::NUM_LANES; g++)
    begin : g_lane
        dpls_lane u_lane (
            .clk    (clk),
            .en     (ready),
            .cmd    (lane_cmd[g]),
            .err    (lane_err[g]),
            .cmp    (cmp),
            .mag    (lane_mag[g]),
            .result (lane_res[g])
        );
    end

    dpls_merge u_merge (
        .clk    (clk),
        .en     (ready),
        .mags   (lane_mag),
        .budget (budget),
        .cmp    (cmp),
        .tail   (tail)
    );

    // result register
    always_comb
    begin
        res_next.limited_lf    = lane_res[dpls_pkg::LANE_LF];
        res_next.limited_rf    = lane_res[dpls_pkg::LANE_RF];
        res_next.limited_lb    = lane_res[dpls_pkg::LANE_LB];
        res_next.limited_rb    = lane_res[dpls_pkg::LANE_RB];
        res_next.was_limited   = tail.limited;
        res_next.output_budget = tail.budget;
    end

    always_ff @(posedge clk)
    begin
        if (ready[dpls_pkg::ST_OUT])
            res_reg <= res_next;
    end

    assign res_valid = v_reg[dpls_pkg::ST_OUT];
    assign res_data  = res_reg;

    // a stalled request means every stage holds an item
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (&v_reg))
        else $error("request stalled while a pipeline stage is empty");

    // limiting against a zero budget clears every wheel
    a_zero_budget_limited: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.was_limited && (res_data.output_budget == 16'd0)) |->
        ((res_data.limited_lf == 16'sd0) && (res_data.limited_rf == 16'sd0) &&
         (res_data.limited_lb == 16'sd0) && (res_data.limited_rb == 16'sd0)))
        else $error("limited result against zero budget is not all zero");

    // an unlimited result against a zero budget can only come from all-zero nudged magnitudes
    a_zero_budget_unlimited: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_data.was_limited && (res_data.output_budget == 16'd0)) |->
        ((res_data.limited_lf == 16'sd0) && (res_data.limited_rf == 16'sd0) &&
         (res_data.limited_lb == 16'sd0) && (res_data.limited_rb == 16'sd0)))
        else $error("nonzero wheel passed unlimited against zero budget");

endmodule

@@ rtl/core/dpls_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module dpls_div (
    input  logic                           clk,
    input  logic [dpls_pkg::DIV_STEPS-1:0] en,
    input  logic [dpls_pkg::DIV_NUM_W-1:0] num,
    input  logic [dpls_pkg::DIV_DEN_W-1:0] den,
    output logic [dpls_pkg::DIV_STEPS-1:0] quo
);

    logic [dpls_pkg::DIV_NUM_W-1:0] rem_reg  [dpls_pkg::DIV_STEPS];
    logic [dpls_pkg::DIV_DEN_W-1:0] den_reg  [dpls_pkg::DIV_STEPS];
    logic [dpls_pkg::DIV_STEPS-1:0] quo_reg  [dpls_pkg::DIV_STEPS];

    logic [dpls_pkg::DIV_NUM_W-1:0] rem_in   [dpls_pkg::DIV_STEPS];
    logic [dpls_pkg::DIV_DEN_W-1:0] den_in   [dpls_pkg::DIV_STEPS];
    logic [dpls_pkg::DIV_STEPS-1:0] quo_in   [dpls_pkg::DIV_STEPS];
    logic [dpls_pkg::DIV_NUM_W-1:0] trial    [dpls_pkg::DIV_STEPS];
    logic [dpls_pkg::DIV_NUM_W-1:0] rem_next [dpls_pkg::DIV_STEPS];
    logic [dpls_pkg::DIV_STEPS-1:0] quo_next [dpls_pkg::DIV_STEPS];

    // stage inputs: first stage from the ports, the rest from the previous stage
    always_comb
    begin
        rem_in[0] = num;
        den_in[0] = den;
        quo_in[0] = '0;
        for (int j = 1; j < dpls_pkg::DIV_STEPS; j++)
        begin
            rem_in[j] = rem_reg[j-1];
            den_in[j] = den_reg[j-1];
            quo_in[j] = quo_reg[j-1];
        end
    end

    // compare and subtract the shifted divisor, msb of the quotient first
    always_comb
    begin
        for (int j = 0; j < dpls_pkg::DIV_STEPS; j++)
        begin
            trial[j] = dpls_pkg::DIV_NUM_W'(den_in[j]) << (dpls_pkg::DIV_STEPS - 1 - j);
            if (rem_in[j] >= trial[j])
            begin
                rem_next[j] = rem_in[j] - trial[j];
                quo_next[j] = quo_in[j] |
                              (dpls_pkg::DIV_STEPS'(1) << (dpls_pkg::DIV_STEPS - 1 - j));
            end
            else
            begin
                rem_next[j] = rem_in[j];
                quo_next[j] = quo_in[j];
            end
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < dpls_pkg::DIV_STEPS; j++)
        begin
            if (en[j])
            begin
                rem_reg[j] <= rem_next[j];
                den_reg[j] <= den_in[j];
                quo_reg[j] <= quo_next[j];
            end
        end
    end

    assign quo = quo_reg[dpls_pkg::DIV_STEPS-1];

endmodule

@@ rtl/core/dpls_budget.sv @@
// output budget from the clamped power buffer and the link state
module dpls_budget (
    input  logic                clk,
    input  dpls_pkg::stage_en_t en,
    input  logic [9:0]          power_buffer,
    input  logic                referee_online,
    input  logic [15:0]         output_max,
    output logic [15:0]         budget
);

    logic [5:0]  buf_clamped;
    logic [12:0] coef;
    logic        cube;
    logic [28:0] prod_next;
    logic [28:0] prod_reg;
    logic        cube_prod_reg;
    logic [29:0] recip;
    logic [63:0] recip_next;
    logic [63:0] recip_reg;
    logic        cube_recip_reg;
    logic [15:0] quo_next;
    logic [15:0] quo_reg;
    logic [15:0] budget_reg;

    // clamp to sixty and pick the curve; offline uses the full square curve
    always_comb
    begin
        if (power_buffer > 10'(dpls_pkg::BUF_FULL))
            buf_clamped = dpls_pkg::BUF_FULL;
        else
            buf_clamped = power_buffer[5:0];
        cube      = referee_online && (buf_clamped < dpls_pkg::BUF_LOW);
        coef      = referee_online ? dpls_pkg::budget_coef(buf_clamped) : dpls_pkg::COEF_FULL;
        prod_next = 29'(output_max) * 29'(coef);
    end

    // divide by sixty cubed or sixty squared through the reciprocal
    always_comb
    begin
        recip      = cube_prod_reg ? dpls_pkg::RECIP_CUBE : dpls_pkg::RECIP_SQUARE;
        recip_next = 64'(prod_reg) * 64'(recip);
        quo_next   = cube_recip_reg ? recip_reg[dpls_pkg::RECIP_CUBE_SHIFT +: 16]
                                    : recip_reg[dpls_pkg::RECIP_SQUARE_SHIFT +: 16];
    end

    always_ff @(posedge clk)
    begin
        if (en[dpls_pkg::ST_PREP])
        begin
            prod_reg      <= prod_next;
            cube_prod_reg <= cube;
        end
        if (en[dpls_pkg::ST_RECIP])
        begin
            recip_reg      <= recip_next;
            cube_recip_reg <= cube_prod_reg;
        end
        if (en[dpls_pkg::ST_NUDGE])
            quo_reg <= quo_next;
        // line up with the lane sum
        if (en[dpls_pkg::ST_BUDGET])
            budget_reg <= quo_reg;
    end

    assign budget = budget_reg;

endmodule

@@ rtl/core/dpls_lane.sv @@
// one wheel lane: error nudge, then budget scaling and saturation
module dpls_lane (
    input  logic                clk,
    input  dpls_pkg::stage_en_t en,
    input  logic signed [15:0]  cmd,
    input  logic signed [2:0]   err,
    input  dpls_pkg::merge_t    cmp,
    output logic [15:0]         mag,
    output logic [15:0]         result
);

    logic [15:0]        cmd_abs;
    logic [15:0]        cmd_neg;
    logic signed [20:0] cmd_x10;
    logic signed [20:0] nudge_part;
    logic signed [20:0] t_next;
    logic signed [19:0] t_reg;
    logic [19:0]        t_neg;
    logic [18:0]        t_abs;
    logic [37:0]        recip_next;
    logic [37:0]        recip_reg;
    logic               recip_neg_reg;

    logic [15:0] mag_pipe_reg [dpls_pkg::ST_NUDGE:dpls_pkg::ST_CMP];
    logic        neg_pipe_reg [dpls_pkg::ST_NUDGE:dpls_pkg::ST_CMP];

    logic [31:0]                    scale_num_reg;
    logic [dpls_pkg::DIV_DEN_W-1:0] scale_den_reg;
    logic [15:0]                    quo;

    logic [15:0] side_mag_reg [dpls_pkg::ST_SCALE_MUL:dpls_pkg::ST_SDIV_LAST];
    logic        side_neg_reg [dpls_pkg::ST_SCALE_MUL:dpls_pkg::ST_SDIV_LAST];
    logic        side_lim_reg [dpls_pkg::ST_SCALE_MUL:dpls_pkg::ST_SDIV_LAST];

    // ten times the command plus its magnitude times the error sum
    always_comb
    begin
        cmd_neg    = 16'(~cmd + 16'sd1);
        cmd_abs    = cmd[15] ? cmd_neg : cmd;
        cmd_x10    = $signed({{5{cmd[15]}}, cmd}) * 21'sd10;
        nudge_part = $signed({5'b0, cmd_abs}) * $signed({{18{err[2]}}, err});
        t_next     = cmd_x10 + nudge_part;
    end

    // magnitude times the reciprocal of ten
    always_comb
    begin
        t_neg      = 20'(~t_reg + 20'sd1);
        t_abs      = t_reg[19] ? t_neg[18:0] : t_reg[18:0];
        recip_next = {19'b0, t_abs} * {19'b0, dpls_pkg::RECIP10};
    end

    always_ff @(posedge clk)
    begin
        if (en[dpls_pkg::ST_PREP])
            t_reg <= t_next[19:0];
        if (en[dpls_pkg::ST_RECIP])
        begin
            recip_reg     <= recip_next;
            recip_neg_reg <= t_reg[19];
        end
        // truncated quotient by ten as sign and magnitude
        if (en[dpls_pkg::ST_NUDGE])
        begin
            mag_pipe_reg[dpls_pkg::ST_NUDGE] <= recip_reg[dpls_pkg::RECIP10_SHIFT +: 16];
            neg_pipe_reg[dpls_pkg::ST_NUDGE] <= recip_neg_reg;
        end
        // hold the nudged command while the budget is divided out
        for (int s = dpls_pkg::ST_NUDGE + 1; s <= dpls_pkg::ST_CMP; s++)
        begin
            if (en[s])
            begin
                mag_pipe_reg[s] <= mag_pipe_reg[s-1];
                neg_pipe_reg[s] <= neg_pipe_reg[s-1];
            end
        end
        // magnitude times budget over the sum
        if (en[dpls_pkg::ST_SCALE_MUL])
        begin
            scale_num_reg <= {16'b0, mag_pipe_reg[dpls_pkg::ST_CMP]} * {16'b0, cmp.budget};
            scale_den_reg <= cmp.sum;
            side_mag_reg[dpls_pkg::ST_SCALE_MUL] <= mag_pipe_reg[dpls_pkg::ST_CMP];
            side_neg_reg[dpls_pkg::ST_SCALE_MUL] <= neg_pipe_reg[dpls_pkg::ST_CMP];
            side_lim_reg[dpls_pkg::ST_SCALE_MUL] <= cmp.limited;
        end
        for (int s = dpls_pkg::ST_SCALE_MUL + 1; s <= dpls_pkg::ST_SDIV_LAST; s++)
        begin
            if (en[s])
            begin
                side_mag_reg[s] <= side_mag_reg[s-1];
                side_neg_reg[s] <= side_neg_reg[s-1];
                side_lim_reg[s] <= side_lim_reg[s-1];
            end
        end
    end

    dpls_div u_div (
        .clk (clk),
        .en  (en[dpls_pkg::ST_SCALE_MUL+1 +: dpls_pkg::DIV_STEPS]),
        .num ({2'b0, scale_num_reg}),
        .den (scale_den_reg),
        .quo (quo)
    );

    assign mag = mag_pipe_reg[dpls_pkg::ST_NUDGE];

    // scaled or unscaled magnitude, signed and saturated
    assign result = dpls_pkg::sat_mag(side_neg_reg[dpls_pkg::ST_SDIV_LAST],
                                      side_lim_reg[dpls_pkg::ST_SDIV_LAST] ?
                                      quo : side_mag_reg[dpls_pkg::ST_SDIV_LAST]);

endmodule

@@ rtl/core/dpls_merge.sv @@
// sums the lane magnitudes and compares the total against the budget
module dpls_merge (
    input  logic                                 clk,
    input  dpls_pkg::stage_en_t                  en,
    input  logic [dpls_pkg::NUM_LANES-1:0][15:0] mags,
    input  logic [15:0]                          budget,
    output dpls_pkg::merge_t                     cmp,
    output dpls_pkg::tail_t                      tail
);

    logic [17:0]      sum_next;
    logic [17:0]      sum_pipe_reg [dpls_pkg::ST_SUM:dpls_pkg::ST_BUDGET];
    dpls_pkg::merge_t cmp_next;
    dpls_pkg::merge_t cmp_reg;
    dpls_pkg::tail_t  tail_pipe_reg [dpls_pkg::ST_SCALE_MUL:dpls_pkg::ST_SDIV_LAST];

    // absolute sum of the four nudged commands
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < dpls_pkg::NUM_LANES; i++)
            sum_next = sum_next + {2'b0, mags[i]};
    end

    // limit decision once the budget is ready
    always_comb
    begin
        cmp_next.sum     = sum_pipe_reg[dpls_pkg::ST_BUDGET];
        cmp_next.budget  = budget;
        cmp_next.limited = sum_pipe_reg[dpls_pkg::ST_BUDGET] > {2'b0, budget};
    end

    always_ff @(posedge clk)
    begin
        if (en[dpls_pkg::ST_SUM])
            sum_pipe_reg[dpls_pkg::ST_SUM] <= sum_next;
        for (int s = dpls_pkg::ST_SUM + 1; s <= dpls_pkg::ST_BUDGET; s++)
        begin
            if (en[s])
                sum_pipe_reg[s] <= sum_pipe_reg[s-1];
        end
        if (en[dpls_pkg::ST_CMP])
            cmp_reg <= cmp_next;
        // flag and budget travel alongside the lane dividers
        if (en[dpls_pkg::ST_SCALE_MUL])
        begin
            tail_pipe_reg[dpls_pkg::ST_SCALE_MUL].limited <= cmp_reg.limited;
            tail_pipe_reg[dpls_pkg::ST_SCALE_MUL].budget  <= cmp_reg.budget;
        end
        for (int s = dpls_pkg::ST_SCALE_MUL + 1; s <= dpls_pkg::ST_SDIV_LAST; s++)
        begin
            if (en[s])
                tail_pipe_reg[s] <= tail_pipe_reg[s-1];
        end
    end

    assign cmp  = cmp_reg;
    assign tail = tail_pipe_reg[dpls_pkg::ST_SDIV_LAST];

endmodule
